@@ hw/rtl/iqfsm_pkg.sv @@
// ----------------------------------------------------------------------------
// iqfsm_pkg
// Shared constants, types and the elaboration-time sine table builder for the
// I/Q byte frequency shift mixer.
// ----------------------------------------------------------------------------
package iqfsm_pkg;

    // Phase accumulator, table and amplitude sizing
    localparam int PHASE_BITS      = 32;
    localparam int TABLE_ADDR_BITS = 10;
    localparam int AMP_BITS        = 16;

    localparam int QTR_BITS = TABLE_ADDR_BITS - 2;
    localparam int QTR_SIZE = 1 << QTR_BITS;
    // Unsigned magnitude width of one table entry
    localparam int AMP_W    = AMP_BITS - 1;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int SAMP_W   = 9;     // 2*byte-255 in -255..255
    localparam int FREQ_W   = 32;
    localparam int OUT_W    = 25;
    localparam int IN_DATA_W  = 2 * BYTE_W;
    localparam int OUT_DATA_W = ((2 * OUT_W + 7) / 8) * 8;

    // Product and sum widths
    localparam int PROD_W = SAMP_W + AMP_BITS;
    localparam int SUM_W  = PROD_W + 1;
    localparam int CALC_W = (SUM_W > OUT_W) ? SUM_W : OUT_W;

    localparam logic [FREQ_W-1:0] FREQ_RESET = 32'hE8CC_CCCD;

    // pi/2 in Q2.62
    localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;
    localparam logic [63:0] AMP_VAL     = (64'd1 << (AMP_BITS - 1)) - 64'd1;

    // First-quadrant sine table, entries 0..QTR_SIZE inclusive
    typedef logic [QTR_SIZE:0][AMP_W-1:0] t_qtab;

    // (a*b) >> s, low 64 bits kept
    function automatic logic [63:0] umul_shr(input logic [63:0] a,
                                             input logic [63:0] b,
                                             input int s);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p >> s;
        return p[63:0];
    endfunction

    // One Taylor step: term / ((2n)(2n+1))
    function automatic logic [63:0] taylor_div(input logic [63:0] term, input int n);
        logic [63:0] q;
        unique case (n)
            1:  q = term / 64'd6;
            2:  q = term / 64'd20;
            3:  q = term / 64'd42;
            4:  q = term / 64'd72;
            5:  q = term / 64'd110;
            6:  q = term / 64'd156;
            7:  q = term / 64'd210;
            8:  q = term / 64'd272;
            9:  q = term / 64'd342;
            10: q = term / 64'd420;
            11: q = term / 64'd506;
            12: q = term / 64'd600;
            13: q = term / 64'd702;
            14: q = term / 64'd812;
            15: q = term / 64'd930;
            16: q = term / 64'd1056;
            17: q = term / 64'd1190;
            18: q = term / 64'd1332;
            19: q = term / 64'd1482;
            20: q = term / 64'd1640;
            default: q = 64'd0;
        endcase
        return q;
    endfunction

    // sin(x) in Q2.62 for x in [0, pi/2]
    function automatic logic [63:0] sin_q62(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x2   = umul_shr(x, x, 62);
        term = x;
        sum  = x;
        for (int n = 1; n <= 20; n++) begin
            term = taylor_div(umul_shr(term, x2, 62), n);
            if ((n % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    // Rounded AMP*sin over the first quadrant, exact AMP at the quarter turn
    function automatic t_qtab build_qtab();
        t_qtab       t;
        logic [63:0] ang;
        logic [63:0] s;
        logic [63:0] v;
        for (int r = 0; r < QTR_SIZE; r++) begin
            ang  = umul_shr(HALF_PI_Q62, 64'(r), QTR_BITS);
            s    = sin_q62(ang);
            v    = (umul_shr(AMP_VAL, s, 61) + 64'd1) >> 1;
            t[r] = v[AMP_W-1:0];
        end
        t[QTR_SIZE] = AMP_VAL[AMP_W-1:0];
        return t;
    endfunction

endpackage

@@ hw/rtl/iq_byte_frequency_shift_mixer.sv @@
// ----------------------------------------------------------------------------
// iq_byte_frequency_shift_mixer
// NCO complex mixer: shifts 8-bit offset-binary I/Q samples in frequency by
// multiplying with e^(j*phase) from a quarter-wave sine table.
//
//   channel | dir | handshake             | payload
//   --------+-----+-----------------------+---------------------------------
//   s       | in  | i_s_tvalid/o_s_tready | i_s_tdata: i_byte, q_byte
//   m       | out | o_m_tvalid/i_m_tready | o_m_tdata: i_out, q_out
//   cfg     | in  | i_cfg_we              | i_cfg_wdata: freq_word
//
// One item per clock sustained while the output is ready. Table lookup feeds
// the sample register, then the complex multiply feeds the result register.
// Each stage advances when it is empty or the stage after it drains, so a
// stalled output does not block input until both stages are full.
// Synchronous active-low reset clears the valids, the phase (to zero) and
// restores the default frequency word.
// ----------------------------------------------------------------------------
module iq_byte_frequency_shift_mixer
    import iqfsm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // sample stream in
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // [7:0] i_byte, [15:8] q_byte
    // shifted stream out
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // [24:0] i_out, [49:25] q_out, pad
    // frequency word
    input  logic                  i_cfg_we,
    input  logic [FREQ_W-1:0]     i_cfg_wdata
);

    localparam t_qtab QTAB = build_qtab();

    // Signed sine at a full-circle table index
    function automatic logic signed [AMP_BITS-1:0] sine_at(
        input logic [TABLE_ADDR_BITS-1:0] idx);
        logic [1:0]            quad;
        logic [QTR_BITS-1:0]   r;
        logic [QTR_BITS:0]     ri;
        logic [AMP_W-1:0]      mag;
        logic signed [AMP_BITS-1:0] v;
        quad = idx[TABLE_ADDR_BITS-1 -: 2];
        r    = idx[QTR_BITS-1:0];
        ri   = quad[0] ? ((QTR_BITS+1)'(QTR_SIZE) - {1'b0, r}) : {1'b0, r};
        mag  = QTAB[ri];
        v    = signed'({1'b0, mag});
        return quad[1] ? -v : v;
    endfunction

    logic                          s_accept;
    logic                          s1_ready;
    logic                          s2_ready;

    logic signed [FREQ_W-1:0]      r_freq_word;
    logic [PHASE_BITS-1:0]         r_phase;
    logic [PHASE_BITS-1:0]         n_phase;

    logic [TABLE_ADDR_BITS-1:0]    tbl_idx;
    logic signed [SAMP_W-1:0]      n_s1_a;
    logic signed [SAMP_W-1:0]      n_s1_b;
    logic signed [AMP_BITS-1:0]    n_s1_c;
    logic signed [AMP_BITS-1:0]    n_s1_d;
    logic signed [SAMP_W:0]        a_wide;
    logic signed [SAMP_W:0]        b_wide;

    logic                          r_s1_valid;
    logic signed [SAMP_W-1:0]      r_s1_a;
    logic signed [SAMP_W-1:0]      r_s1_b;
    logic signed [AMP_BITS-1:0]    r_s1_c;
    logic signed [AMP_BITS-1:0]    r_s1_d;

    logic signed [PROD_W-1:0]      p_ac;
    logic signed [PROD_W-1:0]      p_bd;
    logic signed [PROD_W-1:0]      p_ad;
    logic signed [PROD_W-1:0]      p_bc;
    logic signed [CALC_W-1:0]      sum_re;
    logic signed [CALC_W-1:0]      sum_im;

    logic                          r_s2_valid;
    logic [OUT_W-1:0]              r_i_out;
    logic [OUT_W-1:0]              r_q_out;

    // Stage flow control
    assign s2_ready   = !r_s2_valid || i_m_tready;
    assign s1_ready   = !r_s1_valid || s2_ready;
    assign o_s_tready = s1_ready;
    assign s_accept   = i_s_tvalid && s1_ready;

    // Advance phase by the sign-extended frequency word on each transfer
    assign n_phase = r_phase + PHASE_BITS'(r_freq_word);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq_word <= signed'(FREQ_RESET);
            r_phase     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_freq_word <= signed'(i_cfg_wdata);
            end
            if (s_accept) begin
                r_phase <= n_phase;
            end
        end
    end

    // Map bytes to 2*byte-255 and look up cos/sin at the current phase
    assign a_wide  = signed'({1'b0, i_s_tdata[BYTE_W-1:0], 1'b0}) - (SAMP_W+1)'(255);
    assign b_wide  = signed'({1'b0, i_s_tdata[2*BYTE_W-1:BYTE_W], 1'b0})
                     - (SAMP_W+1)'(255);
    assign n_s1_a  = a_wide[SAMP_W-1:0];
    assign n_s1_b  = b_wide[SAMP_W-1:0];
    assign tbl_idx = r_phase[PHASE_BITS-1 -: TABLE_ADDR_BITS];
    assign n_s1_d  = sine_at(tbl_idx);
    assign n_s1_c  = sine_at(tbl_idx + TABLE_ADDR_BITS'(QTR_SIZE));

    // Sample register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_a <= n_s1_a;
            r_s1_b <= n_s1_b;
            r_s1_c <= n_s1_c;
            r_s1_d <= n_s1_d;
        end
    end

    // Complex multiply at full precision, wrapped to the output width
    assign p_ac   = PROD_W'(r_s1_a * r_s1_c);
    assign p_bd   = PROD_W'(r_s1_b * r_s1_d);
    assign p_ad   = PROD_W'(r_s1_a * r_s1_d);
    assign p_bc   = PROD_W'(r_s1_b * r_s1_c);
    assign sum_re = CALC_W'(p_ac) - CALC_W'(p_bd);
    assign sum_im = CALC_W'(p_ad) + CALC_W'(p_bc);

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && r_s1_valid) begin
            r_i_out <= sum_re[OUT_W-1:0];
            r_q_out <= sum_im[OUT_W-1:0];
        end
    end

    assign o_m_tvalid = r_s2_valid;
    assign o_m_tdata  = {(OUT_DATA_W - 2*OUT_W)'(0), r_q_out, r_i_out};

    // Phase moves only on an input transfer
    a_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_accept |=> $stable(r_phase))
        else $error("phase changed without an input transfer");

    // An accepted item lands in the sample register
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> r_s1_valid)
        else $error("accepted item lost from sample register");

    // With both stages full and output stalled, the sample stage holds
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s2_valid && !i_m_tready)
        |=> (r_s1_valid && $stable(r_s1_a) && $stable(r_s1_c)))
        else $error("sample stage changed under backpressure");

endmodule

@@ sim/tb_iq_byte_frequency_shift_mixer.sv @@
// ----------------------------------------------------------------------------
// tb_iq_byte_frequency_shift_mixer
// Streams byte I/Q pairs through the frequency shift mixer and checks every
// shifted sample against a local NCO model with its own quarter-wave sine
// table. The run covers several frequency words, extremes among them, with
// random idle cycles on both stream sides and one phase of full-rate traffic.
// ----------------------------------------------------------------------------
module tb_iq_byte_frequency_shift_mixer;
    import iqfsm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] QUARTER_TURN_Q62 = 64'h6487_ED51_10B4_611A;
    localparam logic [63:0] PEAK             = 64'd32767;
    localparam logic [31:0] STEP_AT_RESET    = 32'hE8CC_CCCD;
    localparam int          IDLE_PCT         = 22;

    typedef struct packed {
        logic [BYTE_W-1:0] q_byte;
        logic [BYTE_W-1:0] i_byte;
    } t_iq_pair;

    typedef struct packed {
        logic signed [OUT_W-1:0] re;
        logic signed [OUT_W-1:0] im;
    } t_shifted;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata   = '0;    // [7:0] i_byte, [15:8] q_byte
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;           // [24:0] i_out, [49:25] q_out, pad
    logic                  i_cfg_we    = 1'b0;
    logic [FREQ_W-1:0]     i_cfg_wdata = '0;

    // NCO model state
    int                    sine_quarter [0:QTR_SIZE];
    logic [PHASE_BITS-1:0] nco_phase = '0;
    logic [FREQ_W-1:0]     nco_step  = STEP_AT_RESET;

    t_iq_pair pending_pairs [$];
    t_iq_pair staged_pair;
    t_shifted expected_mix [$];
    t_shifted seen_mix;
    int       mismatch_count = 0;
    bit       steady = 1'b0;

    iq_byte_frequency_shift_mixer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Unsigned 64x64 product shifted right, low 64 bits kept
    function automatic logic [63:0] mul_shift(input logic [63:0] x, input logic [63:0] y,
                                              input int unsigned sh);
        logic [127:0] full;
        full = {64'd0, x} * {64'd0, y};
        full = full >> sh;
        return full[63:0];
    endfunction

    // Taylor series for sin on the first quadrant, Q2.62 in and out
    function automatic logic [63:0] taylor_sine(input logic [63:0] ang);
        logic [63:0] sq;
        logic [63:0] term;
        logic [63:0] acc;
        int unsigned k;
        sq   = mul_shift(ang, ang, 62);
        term = ang;
        acc  = ang;
        k    = 1;
        while (k < 40 && term != 0) begin
            term = mul_shift(term, sq, 62) / (64'(2 * k) * 64'(2 * k + 1));
            if (k % 2 == 1) begin
                acc = acc - term;
            end else begin
                acc = acc + term;
            end
            k++;
        end
        return acc;
    endfunction

    // Fill the quarter-wave table, exact peak at the quarter turn
    task automatic build_sine_quarter();
        logic [63:0] s;
        for (int r = 0; r < QTR_SIZE; r++) begin
            s = taylor_sine(mul_shift(QUARTER_TURN_Q62, 64'(r), QTR_BITS));
            sine_quarter[r] = int'((mul_shift(PEAK, s, 61) + 64'd1) >> 1);
        end
        sine_quarter[QTR_SIZE] = int'(PEAK);
    endtask

    // Full-circle sine from the quarter table by quadrant symmetry
    function automatic int sine_lookup(input logic [TABLE_ADDR_BITS-1:0] idx);
        logic [1:0] quad;
        int         r;
        int         mag;
        quad = idx[TABLE_ADDR_BITS-1 -: 2];
        r    = int'(idx[QTR_BITS-1:0]);
        mag  = quad[0] ? sine_quarter[QTR_SIZE - r] : sine_quarter[r];
        return quad[1] ? -mag : mag;
    endfunction

    // Mix one accepted pair at the current phase, then advance the NCO
    task automatic mix_sample(input t_iq_pair p);
        int                         a, b, c, d;
        logic [TABLE_ADDR_BITS-1:0] sidx;
        logic [TABLE_ADDR_BITS-1:0] cidx;
        t_shifted                   res;
        a    = 2 * int'(p.i_byte) - 255;
        b    = 2 * int'(p.q_byte) - 255;
        sidx = nco_phase[PHASE_BITS-1 -: TABLE_ADDR_BITS];
        cidx = sidx + TABLE_ADDR_BITS'(QTR_SIZE);
        d    = sine_lookup(sidx);
        c    = sine_lookup(cidx);
        res.re = OUT_W'(a * c - b * d);
        res.im = OUT_W'(a * d + b * c);
        expected_mix = {expected_mix, res};
        nco_phase = nco_phase + PHASE_BITS'(signed'(nco_step));
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Source side: hold the pair until taken, predict at each transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (i_s_tvalid) begin
                mix_sample(t_iq_pair'(i_s_tdata));
            end
            if (pending_pairs.size() != 0 &&
                (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                staged_pair = pending_pairs.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= staged_pair;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Sink side: check each transfer against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_mix.size() == 0) begin
                    flag_mismatch("unexpected result", 32'(o_m_tdata[OUT_W-1:0]), 32'd0);
                end else begin
                    seen_mix = expected_mix.pop_front();
                    if (o_m_tdata[OUT_W-1:0] !== seen_mix.re) begin
                        flag_mismatch("i_out", 32'(o_m_tdata[OUT_W-1:0]), 32'(seen_mix.re));
                    end
                    if (o_m_tdata[2*OUT_W-1:OUT_W] !== seen_mix.im) begin
                        flag_mismatch("q_out", 32'(o_m_tdata[2*OUT_W-1:OUT_W]),
                                      32'(seen_mix.im));
                    end
                end
            end
            i_m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic queue_pair(input logic [BYTE_W-1:0] ib, input logic [BYTE_W-1:0] qb);
        t_iq_pair p;
        p.i_byte = ib;
        p.q_byte = qb;
        pending_pairs = {pending_pairs, p};
    endtask

    // Mostly full-range random bytes, with the rails mixed in
    function automatic logic [BYTE_W-1:0] pick_byte();
        unique case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Wait until every pair is taken and every result checked
    task automatic wait_drain(input int settle);
        while (pending_pairs.size() != 0 || i_s_tvalid || expected_mix.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic write_step(input logic [FREQ_W-1:0] w);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        nco_step = w;
        @(negedge i_clk);
    endtask

    initial begin
        logic [FREQ_W-1:0] step_plan [$];
        build_sine_quarter();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pairs at the reset frequency word
        queue_pair(8'd0, 8'd0);
        queue_pair(8'd255, 8'd255);
        queue_pair(8'd0, 8'd255);
        queue_pair(8'd255, 8'd0);
        queue_pair(8'd127, 8'd128);
        queue_pair(8'd128, 8'd127);
        queue_pair(8'd127, 8'd127);
        queue_pair(8'd128, 8'd128);
        queue_pair(8'd1, 8'd254);
        queue_pair(8'd170, 8'd85);
        queue_pair(8'd85, 8'd170);
        queue_pair(8'd255, 8'd128);
        for (int i = 0; i < 8; i++) begin
            queue_pair(8'd255, 8'd0);
        end
        wait_drain(4);

        // Zero, both extremes, single table step, quarter turn, tiny steps, random, reset word
        step_plan = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0040_0000,
                      32'h4000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'($urandom()),
                      32'($urandom()), STEP_AT_RESET};
        foreach (step_plan[ph]) begin
            write_step(step_plan[ph]);
            steady = (ph == 3);
            for (int i = 0; i < 80; i++) begin
                queue_pair(pick_byte(), pick_byte());
            end
            wait_drain(4);
            steady = 1'b0;
        end

        wait_drain(8);
        if (mismatch_count == 0 && expected_mix.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #1_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
